[hdl/gcm_pkg.sv]
package gcm_pkg;

  localparam int unsigned MaxCoinsDef = 4;
  localparam int unsigned ValW        = 16;
  localparam int unsigned StockW      = 10;
  localparam int unsigned SlotW       = 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned UseW        = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgCoinsInUse = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCoinValue0 = 3'd1;

  // action codes of an input item
  localparam logic ActLoad   = 1'b0;
  localparam logic ActChange = 1'b1;

  localparam logic [UseW-1:0] CoinsInUseRst = 3'd4;

  // one candidate slot as seen by the shared compare unit
  typedef struct packed {
    logic [ValW-1:0] value;
    logic            stock_nz;
  } cand_t;

  function automatic logic [ValW-1:0] coin_reset(input int unsigned i);
    logic [ValW-1:0] v;
    unique case (i)
      0:       v = 16'd1;
      1:       v = 16'd2;
      2:       v = 16'd5;
      3:       v = 16'd10;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/gcm_pick.sv]
module gcm_pick (
  input  gcm_pkg::cand_t              cand_i,
  input  logic [gcm_pkg::ValW-1:0]    total_i,
  input  logic [gcm_pkg::ValW-1:0]    amount_i,
  input  logic [gcm_pkg::ValW-1:0]    best_i,
  output logic                        take_o
);

  logic [gcm_pkg::ValW:0] sum;

  // coin must beat the best so far, be in stock and not overshoot
  assign sum    = {1'b0, total_i} + {1'b0, cand_i.value};
  assign take_o = (cand_i.value > best_i) && cand_i.stock_nz && (sum <= {1'b0, amount_i});

endmodule

[hdl/greedy_change_maker.sv]
// Load item: taken while idle, no result; ready again the next cycle.
// Change item: a check, then per coin a scan of the n slots in use and a check
// (n = slots in use), one more scan on a failure, then one result per slot in use.
// Input ready only while idle, so a new item is taken only after the last result.
// Reset clears stock, used counts and control; coin values return to 1, 2, 5, 10.
module greedy_change_maker #(
  parameter int unsigned MAX_COINS = gcm_pkg::MaxCoinsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gcm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gcm_pkg::ValW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [gcm_pkg::SlotW-1:0]     slot_i,
  input  logic [gcm_pkg::StockW-1:0]    stock_value_i,
  input  logic [gcm_pkg::ValW-1:0]      amount_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gcm_pkg::SlotW-1:0]     slot_out_o,
  output logic [gcm_pkg::StockW-1:0]    used_count_o,
  output logic                          success_o,
  output logic                          last_o
);

  localparam int unsigned IdxW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [gcm_pkg::UseW-1:0]     in_use_q;
  logic [gcm_pkg::ValW-1:0]     value_q [MAX_COINS];
  logic [gcm_pkg::StockW-1:0]   stock_q [MAX_COINS];
  logic [gcm_pkg::StockW-1:0]   used_q  [MAX_COINS];
  logic [gcm_pkg::ValW-1:0]     total_q, amount_q, best_q;
  logic [IdxW-1:0]              pick_q, idx_q;
  logic                         ok_q;

  logic [gcm_pkg::UseW-1:0]     last3;
  logic [IdxW-1:0]              last_idx;
  logic [gcm_pkg::CfgIdxW-1:0]  cfg_off;
  logic                         take;
  logic [gcm_pkg::ValW-1:0]     best_fin;
  logic [IdxW-1:0]              pick_fin;
  gcm_pkg::cand_t               cand;

  // clamp slots in use to 1..MAX_COINS, kept as last index
  always_comb begin
    priority if (in_use_q == '0) begin
      last3 = '0;
    end else if (in_use_q > gcm_pkg::UseW'(MAX_COINS)) begin
      last3 = gcm_pkg::UseW'(MAX_COINS - 1);
    end else begin
      last3 = in_use_q - 3'd1;
    end
  end
  assign last_idx = last3[IdxW-1:0];

  assign cfg_ready_o = 1'b1;
  assign cfg_off     = cfg_index_i - gcm_pkg::CfgCoinValue0;

  assign cand.value    = value_q[idx_q];
  assign cand.stock_nz = (stock_q[idx_q] != '0);

  gcm_pick u_pick (
    .cand_i   (cand),
    .total_i  (total_q),
    .amount_i (amount_q),
    .best_i   (best_q),
    .take_o   (take)
  );

  assign best_fin = take ? cand.value : best_q;
  assign pick_fin = take ? idx_q : pick_q;

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = (state_q == StEmit);
  assign slot_out_o   = gcm_pkg::SlotW'(idx_q);
  assign used_count_o = used_q[idx_q];
  assign success_o    = ok_q;
  assign last_o       = (idx_q == last_idx);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i && (action_i == gcm_pkg::ActChange)) state_d = StCheck;
      StCheck: state_d = (total_q == amount_q) ? StEmit : StScan;
      StScan:  if (idx_q == last_idx) state_d = (best_fin == '0) ? StEmit : StCheck;
      StEmit:  if (out_ready_i && (idx_q == last_idx)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      in_use_q <= gcm_pkg::CoinsInUseRst;
      for (int i = 0; i < MAX_COINS; i++) begin
        value_q[i] <= gcm_pkg::coin_reset(i);
        stock_q[i] <= '0;
        used_q[i]  <= '0;
      end
      total_q  <= '0;
      ok_q     <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        if (cfg_index_i == gcm_pkg::CfgCoinsInUse) begin
          in_use_q <= cfg_data_i[gcm_pkg::UseW-1:0];
        end else if ((cfg_index_i >= gcm_pkg::CfgCoinValue0) &&
                     (cfg_off < gcm_pkg::CfgIdxW'(MAX_COINS))) begin
          value_q[cfg_off[IdxW-1:0]] <= cfg_data_i;
        end
      end

      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            if (action_i == gcm_pkg::ActChange) begin
              for (int i = 0; i < MAX_COINS; i++) used_q[i] <= '0;
              total_q <= '0;
            end else if ({1'b0, slot_i} < (gcm_pkg::SlotW + 1)'(MAX_COINS)) begin
              stock_q[slot_i[IdxW-1:0]] <= stock_value_i;
            end
          end
        end
        StCheck: begin
          idx_q <= '0;
          if (total_q == amount_q) ok_q <= 1'b1;
        end
        StScan: begin
          if (idx_q == last_idx) begin
            idx_q <= '0;
            if (best_fin == '0) begin
              ok_q <= 1'b0;
            end else begin
              // commit the chosen coin
              total_q           <= total_q + best_fin;
              stock_q[pick_fin] <= stock_q[pick_fin] - gcm_pkg::StockW'(1);
              used_q[pick_fin]  <= used_q[pick_fin] + gcm_pkg::StockW'(1);
            end
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        StEmit: begin
          if (out_ready_i && (idx_q != last_idx)) idx_q <= idx_q + IdxW'(1);
        end
        default: ;
      endcase
    end
  end

  // scan scratch registers, no reset needed
  always_ff @(posedge clk_i) begin
    if ((state_q == StIdle) && in_valid_i && (action_i == gcm_pkg::ActChange)) begin
      amount_q <= amount_i;
    end
    if (state_q == StCheck) begin
      best_q <= '0;
      pick_q <= '0;
    end else if (state_q == StScan) begin
      best_q <= best_fin;
      pick_q <= pick_fin;
    end
  end

endmodule

[tb/tb_greedy_change_maker.sv]
module tb_greedy_change_maker;

  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned Rounds        = 8;
  localparam int unsigned ItemsPerRound = 60;

  typedef struct packed {
    logic [gcm_pkg::SlotW-1:0]  slot;
    logic [gcm_pkg::StockW-1:0] used;
    logic                       success;
    logic                       last;
  } payout_t;

  class change_book;
    logic [gcm_pkg::UseW-1:0]   in_use;
    logic [gcm_pkg::ValW-1:0]   face [gcm_pkg::MaxCoinsDef];
    logic [gcm_pkg::StockW-1:0] stock [gcm_pkg::MaxCoinsDef];
    payout_t                    due_payouts [$];
    int unsigned                errors;

    function new();
      in_use = gcm_pkg::CoinsInUseRst;
      face   = '{16'd1, 16'd2, 16'd5, 16'd10};
      for (int i = 0; i < gcm_pkg::MaxCoinsDef; i++) stock[i] = '0;
      errors = 0;
    endfunction

    function int unsigned slots_in_use();
      int unsigned n;
      n = in_use;
      if (n < 1) n = 1;
      if (n > gcm_pkg::MaxCoinsDef) n = gcm_pkg::MaxCoinsDef;
      return n;
    endfunction

    function void write_reg(logic [gcm_pkg::CfgIdxW-1:0] idx,
                            logic [gcm_pkg::ValW-1:0] data);
      if (idx == gcm_pkg::CfgCoinsInUse) begin
        in_use = data[gcm_pkg::UseW-1:0];
      end else if (idx >= gcm_pkg::CfgCoinValue0 &&
                   idx < gcm_pkg::CfgCoinValue0 + gcm_pkg::MaxCoinsDef) begin
        face[idx - gcm_pkg::CfgCoinValue0] = data;
      end
    endfunction

    // Greedy payout: largest fitting coin in stock, lowest slot on a tie.
    function void note_item(logic act, logic [gcm_pkg::SlotW-1:0] slot,
                            logic [gcm_pkg::StockW-1:0] stock_value,
                            logic [gcm_pkg::ValW-1:0] amount);
      int unsigned                n, total, best, pick;
      logic [gcm_pkg::StockW-1:0] used [gcm_pkg::MaxCoinsDef];
      bit                         ok;
      payout_t                    p;
      if (act == gcm_pkg::ActLoad) begin
        if (slot < gcm_pkg::MaxCoinsDef) stock[slot] = stock_value;
        return;
      end
      n     = slots_in_use();
      total = 0;
      ok    = 1'b1;
      for (int i = 0; i < gcm_pkg::MaxCoinsDef; i++) used[i] = '0;
      while (ok && total != amount) begin
        best = 0;
        pick = 0;
        for (int i = 0; i < n; i++) begin
          if (face[i] > best && stock[i] != 0 && total + face[i] <= amount) begin
            best = face[i];
            pick = i;
          end
        end
        if (best == 0) begin
          ok = 1'b0;
        end else begin
          total       += best;
          stock[pick] -= 1'b1;
          used[pick]  += 1'b1;
        end
      end
      for (int k = 0; k < n; k++) begin
        p.slot    = gcm_pkg::SlotW'(k);
        p.used    = used[k];
        p.success = ok;
        p.last    = (k == n - 1);
        due_payouts.push_back(p);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(payout_t got);
      payout_t want;
      if (due_payouts.size() == 0) begin
        report($sformatf("unexpected result: slot %0d used %0d success %0b last %0b",
                         got.slot, got.used, got.success, got.last));
        return;
      end
      want = due_payouts.pop_front();
      if (got.slot !== want.slot || got.used !== want.used ||
          got.success !== want.success || got.last !== want.last) begin
        report($sformatf("got/exp slot %0d/%0d used %0d/%0d success %0b/%0b last %0b/%0b",
                         got.slot, want.slot, got.used, want.used,
                         got.success, want.success, got.last, want.last));
      end
    endtask

    function int unsigned pending();
      return due_payouts.size();
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_valid   = 1'b0;
  logic                        cfg_ready;
  logic [gcm_pkg::CfgIdxW-1:0] cfg_index   = '0;
  logic [gcm_pkg::ValW-1:0]    cfg_data    = '0;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  logic                        action      = 1'b0;
  logic [gcm_pkg::SlotW-1:0]   slot        = '0;
  logic [gcm_pkg::StockW-1:0]  stock_value = '0;
  logic [gcm_pkg::ValW-1:0]    amount      = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  logic [gcm_pkg::SlotW-1:0]   slot_out;
  logic [gcm_pkg::StockW-1:0]  used_count;
  logic                        success;
  logic                        last;
  payout_t                     seen;

  change_book  book;
  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 61;
  int unsigned hold_reqs   = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  greedy_change_maker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .slot_i        (slot),
    .stock_value_i (stock_value),
    .amount_i      (amount),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .slot_out_o    (slot_out),
    .used_count_o  (used_count),
    .success_o     (success),
    .last_o        (last)
  );

  always #5 clk_i = ~clk_i;

  assign seen = {slot_out, used_count, success, last};

  // receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) book.check_result(seen);
  end

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic pace();
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(logic act, logic [gcm_pkg::SlotW-1:0] s,
                           logic [gcm_pkg::StockW-1:0] sv,
                           logic [gcm_pkg::ValW-1:0] amt);
    in_valid    <= 1'b1;
    action      <= act;
    slot        <= s;
    stock_value <= sv;
    amount      <= amt;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    book.note_item(act, s, sv, amt);
    pace();
  endtask

  task automatic load(logic [gcm_pkg::SlotW-1:0] s, logic [gcm_pkg::StockW-1:0] sv);
    send_item(gcm_pkg::ActLoad, s, sv, gcm_pkg::ValW'($urandom));
  endtask

  task automatic change(logic [gcm_pkg::ValW-1:0] amt);
    send_item(gcm_pkg::ActChange, gcm_pkg::SlotW'($urandom),
              gcm_pkg::StockW'($urandom), amt);
  endtask

  // hold the sender until every payout is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [gcm_pkg::CfgIdxW-1:0] idx,
                           logic [gcm_pkg::ValW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    book.write_reg(idx, data);
  endtask

  task automatic apply_setting(logic [gcm_pkg::UseW-1:0] n_use,
                               logic [gcm_pkg::ValW-1:0] v0,
                               logic [gcm_pkg::ValW-1:0] v1,
                               logic [gcm_pkg::ValW-1:0] v2,
                               logic [gcm_pkg::ValW-1:0] v3, bit past_end);
    logic [gcm_pkg::ValW-1:0] v [gcm_pkg::MaxCoinsDef];
    logic [gcm_pkg::ValW-1:0] data;
    v[0] = v0;
    v[1] = v1;
    v[2] = v2;
    v[3] = v3;
    drain();
    data                    = gcm_pkg::ValW'($urandom);
    data[gcm_pkg::UseW-1:0] = n_use;
    cfg_write(gcm_pkg::CfgCoinsInUse, data);
    for (int i = 0; i < gcm_pkg::MaxCoinsDef; i++) begin
      cfg_write(gcm_pkg::CfgIdxW'(gcm_pkg::CfgCoinValue0 + i), v[i]);
    end
    if (past_end) begin
      for (int i = gcm_pkg::CfgCoinValue0 + gcm_pkg::MaxCoinsDef;
           i < 2 ** gcm_pkg::CfgIdxW; i++) begin
        cfg_write(gcm_pkg::CfgIdxW'(i), gcm_pkg::ValW'($urandom));
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setting();
    logic [gcm_pkg::ValW-1:0] v [gcm_pkg::MaxCoinsDef];
    int unsigned              r;
    for (int i = 0; i < gcm_pkg::MaxCoinsDef; i++) begin
      r = $urandom_range(99);
      if (r < 10)      v[i] = '0;
      else if (r < 18) v[i] = '1;
      else if (r < 35) v[i] = gcm_pkg::ValW'($urandom);
      else             v[i] = gcm_pkg::ValW'($urandom_range(1, 25));
    end
    apply_setting(gcm_pkg::UseW'($urandom_range(0, 7)), v[0], v[1], v[2], v[3],
                  1'($urandom_range(1)));
  endtask

  // mostly sums of coins in play, so that many requests can succeed
  function automatic logic [gcm_pkg::ValW-1:0] pick_amount();
    int unsigned r, sum, n;
    r = $urandom_range(99);
    n = book.slots_in_use();
    if (r < 60) begin
      sum = 0;
      repeat ($urandom_range(1, 6)) sum += book.face[$urandom_range(0, n - 1)];
      return gcm_pkg::ValW'(sum);
    end else if (r < 85) begin
      return gcm_pkg::ValW'($urandom_range(0, 60));
    end else if (r < 90) begin
      return '0;
    end
    return gcm_pkg::ValW'($urandom);
  endfunction

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) begin
      load(gcm_pkg::SlotW'($urandom_range(0, 3)), 10'd1023);
    end else if (r < 8) begin
      load(gcm_pkg::SlotW'($urandom_range(0, 3)), gcm_pkg::StockW'($urandom_range(0, 1023)));
    end else if (r < 30) begin
      load(gcm_pkg::SlotW'($urandom_range(0, 3)), gcm_pkg::StockW'($urandom_range(0, 40)));
    end else begin
      change(pick_amount());
    end
  endtask

  initial begin
    int unsigned saved_pct;
    book = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stock with reset coin values
    change(16'd0);
    change(16'd1);
    load(2'd0, 10'd1023);
    load(2'd1, 10'd5);
    load(2'd2, 10'd3);
    load(2'd3, 10'd2);
    change(16'd18);
    change(16'hFFFF);
    load(2'd1, 10'd341);
    load(2'd2, 10'd682);
    load(2'd3, 10'd1023);
    change(16'hAAAA);
    change(16'h5555);
    // coins taken before a failure stay out of stock
    load(2'd0, 10'd0);
    load(2'd1, 10'd1);
    change(16'd3);

    apply_setting(3'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b0);
    load(2'd0, 10'd1023);
    change(16'hFFFF);
    change(16'hFFFE);

    // zero slots in use acts as one
    apply_setting(3'd0, 16'd7, 16'd7, 16'd7, 16'd7, 1'b0);
    change(16'd14);

    // saturated slot count, equal faces, a zero face never picked
    apply_setting(3'd7, 16'd5, 16'd5, 16'd3, 16'd0, 1'b1);
    load(2'd1, 10'd2);
    load(2'd2, 10'd1);
    load(2'd3, 10'd9);
    change(16'd13);
    change(16'd1);

    for (int rnd = 0; rnd < Rounds; rnd++) begin
      if (rnd < 3) begin
        tx_idle_pct = 19;
        rx_idle_pct = 61;
      end else if (rnd < 6) begin
        tx_idle_pct = 61;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_setting();
      for (int k = 0; k < ItemsPerRound; k++) begin
        if (rnd == 2 && k == 20) begin
          // stall the receiver and keep offering requests back to back
          hold_reqs++;
          saved_pct   = tx_idle_pct;
          tx_idle_pct = 0;
          repeat (12) change(pick_amount());
          tx_idle_pct = saved_pct;
        end
        random_item();
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/gcm_pkg.sv
hdl/gcm_pick.sv
hdl/greedy_change_maker.sv
tb/tb_greedy_change_maker.sv
